// ----- rtl/tpm_pkg.sv -----
`timescale 1ns / 1ps

package tpm_pkg;

  localparam int MAX_K       = 4096;
  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROWS        = MAX_K / LANES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int IDX_W       = 12;
  localparam int KLEN_W      = 13;
  localparam int CNT_W       = 16;
  localparam int ACT_W       = 16;
  localparam int SCALE_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 2;
  localparam int ACC_W       = 29;
  localparam int PROD_W      = ACC_W + SCALE_W;
  localparam int FRAC        = 12;
  localparam int Y_W         = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH  = 8;
  localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W  = RESQ_PTR_W + 1;

  localparam logic             CFG_K_LEN     = 1'b0;
  localparam logic             CFG_COL_COUNT = 1'b1;

  localparam logic [CODE_W-1:0] CODE_SKIP = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ADD  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_SUB  = 2'd2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_WEIGHT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         act_index;
    logic signed [ACT_W-1:0]  act_value;
    logic [ROW_W-1:0]         row;
    logic [BYTE_W-1:0]        codes;
    logic                     end_col;
    logic signed [SCALE_W-1:0] scale;
    logic [CNT_W-1:0]         column_index;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic signed [Y_W-1:0]    y_value;
    logic [CNT_W-1:0]         column_index;
    logic                     last;
  } res_t;

endpackage

// ----- rtl/tpm_front.sv -----
`timescale 1ns / 1ps

module tpm_front
  import tpm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      accept,
  input  logic                      mode,
  input  logic [IDX_W-1:0]          act_index,
  input  logic signed [ACT_W-1:0]   act_value,
  input  logic [BYTE_W-1:0]         weight_byte,
  input  logic signed [SCALE_W-1:0] col_scale,
  output cmd_t                      cmd
);

  logic [KLEN_W-1:0] k_len;
  logic [CNT_W-1:0]  col_count;
  logic [ROW_W-1:0]  byte_position;
  logic [CNT_W-1:0]  column_counter;

  logic [KLEN_W-1:0] k_eff;
  logic [KLEN_W-1:0] nbytes;
  logic [CNT_W-1:0]  cols;
  logic              end_col;
  logic              last;
  logic [BYTE_W-1:0] codes;

  always_comb begin
    priority if (k_len == '0) begin
      k_eff = KLEN_W'(1);
    end else if (k_len > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = k_len;
    end
    nbytes  = (k_eff + KLEN_W'(LANES - 1)) >> LANE_W;
    end_col = (KLEN_W'(byte_position) + KLEN_W'(1)) >= nbytes;
    cols    = (col_count == '0) ? CNT_W'(1) : col_count;
    last    = ({1'b0, column_counter} + (CNT_W + 1)'(1)) >= {1'b0, cols};
    for (int l = 0; l < LANES; l++) begin
      if (KLEN_W'({byte_position, LANE_W'(l)}) < k_eff) begin
        codes[CODE_W*l +: CODE_W] = weight_byte[CODE_W*l +: CODE_W];
      end else begin
        codes[CODE_W*l +: CODE_W] = CODE_SKIP;
      end
    end
  end

  always_comb begin
    cmd.op           = op_t'(mode);
    cmd.act_index    = act_index;
    cmd.act_value    = act_value;
    cmd.row          = byte_position;
    cmd.codes        = codes;
    cmd.end_col      = end_col;
    cmd.scale        = col_scale;
    cmd.column_index = column_counter;
    cmd.last         = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_len          <= KLEN_W'(MAX_K);
      col_count      <= CNT_W'(1);
      byte_position  <= '0;
      column_counter <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_K_LEN:     k_len     <= cfg_data[KLEN_W-1:0];
          CFG_COL_COUNT: col_count <= cfg_data[CNT_W-1:0];
          default:       k_len     <= k_len;
        endcase
      end
      if (accept && op_t'(mode) == OP_WEIGHT) begin
        if (end_col) begin
          byte_position  <= '0;
          column_counter <= last ? '0 : column_counter + CNT_W'(1);
        end else begin
          byte_position  <= byte_position + ROW_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/tpm_cmd_queue.sv -----
`timescale 1ns / 1ps

module tpm_cmd_queue
  import tpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;

  assign full     = count == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + (CMDQ_PTR_W + 1)'(1);
        2'b01:   count <= count - (CMDQ_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tpm_back.sv -----
`timescale 1ns / 1ps

module tpm_back
  import tpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_empty,
  input  logic res_pop,
  output res_t res
);

  logic                      s1_valid;
  logic [BYTE_W-1:0]         s1_codes;
  logic                      s1_end;
  logic signed [SCALE_W-1:0] s1_scale;
  logic [CNT_W-1:0]          s1_col;
  logic                      s1_last;
  logic signed [ACT_W-1:0]   rd_data [LANES];

  logic signed [ACC_W-1:0]   accumulator;
  logic signed [ACC_W-1:0]   acc_next;

  logic                      s2_valid;
  logic signed [ACC_W-1:0]   s2_total;
  logic signed [SCALE_W-1:0] s2_scale;
  logic [CNT_W-1:0]          s2_col;
  logic                      s2_last;

  logic                      s3_valid;
  logic signed [PROD_W-1:0]  s3_prod;
  logic [CNT_W-1:0]          s3_col;
  logic                      s3_last;

  logic signed [PROD_W-FRAC-1:0] shifted;
  res_t                      res_in;

  res_t                      res_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0]     res_wr_ptr;
  logic [RESQ_PTR_W-1:0]     res_rd_ptr;
  logic [RESQ_CNT_W-1:0]     res_count;
  logic [RESQ_CNT_W-1:0]     in_flight;
  logic                      res_take;

  assign in_flight = RESQ_CNT_W'(s1_valid & s1_end) + RESQ_CNT_W'(s2_valid)
                   + RESQ_CNT_W'(s3_valid);
  assign cmd_pop   = cmd_valid && (res_count + in_flight < RESQ_CNT_W'(RESQ_DEPTH));

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    logic signed [ACT_W-1:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (cmd_pop && cmd.op == OP_LOAD && cmd.act_index[LANE_W-1:0] == LANE_W'(g)) begin
        mem[cmd.act_index[IDX_W-1:LANE_W]] <= cmd.act_value;
      end
      if (cmd_pop && cmd.op == OP_WEIGHT) begin
        rd_data[g] <= mem[cmd.row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && cmd.op == OP_WEIGHT;
    end
    s1_codes <= cmd.codes;
    s1_end   <= cmd.end_col;
    s1_scale <= cmd.scale;
    s1_col   <= cmd.column_index;
    s1_last  <= cmd.last;
  end

  always_comb begin
    acc_next = accumulator;
    for (int l = 0; l < LANES; l++) begin
      unique case (s1_codes[CODE_W*l +: CODE_W])
        CODE_ADD: acc_next = acc_next + ACC_W'(rd_data[l]);
        CODE_SUB: acc_next = acc_next - ACC_W'(rd_data[l]);
        default:  acc_next = acc_next;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
    end else begin
      if (s1_valid) begin
        accumulator <= s1_end ? '0 : acc_next;
      end
      s2_valid <= s1_valid && s1_end;
      s3_valid <= s2_valid;
    end
    s2_total <= acc_next;
    s2_scale <= s1_scale;
    s2_col   <= s1_col;
    s2_last  <= s1_last;
    s3_prod  <= PROD_W'(s2_total) * PROD_W'(s2_scale);
    s3_col   <= s2_col;
    s3_last  <= s2_last;
  end

  always_comb begin
    shifted = s3_prod[PROD_W-1:FRAC];
    if (shifted[Y_W] != shifted[Y_W-1]) begin
      res_in.y_value = shifted[Y_W] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end else begin
      res_in.y_value = shifted[Y_W-1:0];
    end
    res_in.column_index = s3_col;
    res_in.last         = s3_last;
  end

  assign res_empty = res_count == '0;
  assign res       = res_q[res_rd_ptr];
  assign res_take  = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      res_q[res_wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (s3_valid) begin
        res_wr_ptr <= res_wr_ptr + RESQ_PTR_W'(1);
      end
      if (res_take) begin
        res_rd_ptr <= res_rd_ptr + RESQ_PTR_W'(1);
      end
      unique case ({s3_valid, res_take})
        2'b10:   res_count <= res_count + RESQ_CNT_W'(1);
        2'b01:   res_count <= res_count - RESQ_CNT_W'(1);
        default: res_count <= res_count;
      endcase
    end
  end

endmodule

// ----- rtl/ternary_packed_matvec.sv -----
`timescale 1ns / 1ps
// Channel  | Ports                                              | Transaction
// ---------+----------------------------------------------------+---------------------------
// input    | push, full, mode, act_index, act_value,            | push && !full
//          | weight_byte, col_scale                             |
// result   | empty, pop, y_value, column_index, last_column     | pop && !empty
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data          | cfg_valid && cfg_ready
//
// One item per cycle sustained while full is low; once its last weight byte is taken,
// a column result passes the queue, bank read, accumulate, multiply and result queue.
// The four activation banks give one read of four lanes per cycle when a weight command is popped.
// rst is synchronous and clears counters, queues and the accumulator.
// full rises only when the four-entry command queue fills, which happens once the
// eight-entry result queue backs up because pop is held low.
module ternary_packed_matvec
  import tpm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      mode,
  input  logic [IDX_W-1:0]          act_index,
  input  logic signed [ACT_W-1:0]   act_value,
  input  logic [BYTE_W-1:0]         weight_byte,
  input  logic signed [SCALE_W-1:0] col_scale,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [Y_W-1:0]     y_value,
  output logic [CNT_W-1:0]          column_index,
  output logic                      last_column,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic accept;
  cmd_t front_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  res_t res;

  assign cfg_ready    = 1'b1;
  assign accept       = push && !full;
  assign y_value      = res.y_value;
  assign column_index = res.column_index;
  assign last_column  = res.last;

  tpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .mode       (mode),
    .act_index  (act_index),
    .act_value  (act_value),
    .weight_byte(weight_byte),
    .col_scale  (col_scale),
    .cmd        (front_cmd)
  );

  tpm_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_cmd)
  );

  tpm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd      (q_cmd),
    .cmd_pop  (q_pop),
    .res_empty(empty),
    .res_pop  (pop),
    .res      (res)
  );

endmodule
